>>> hdl/usb_capture_record_classifier_assert.svh
// Assertion macros shared by the classifier modules.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef USB_CAPTURE_RECORD_CLASSIFIER_ASSERT_SVH
`define USB_CAPTURE_RECORD_CLASSIFIER_ASSERT_SVH

// Same-cycle implication.
`define UCRC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define UCRC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/ucrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ucrc_pkg;

	// Result kinds
	typedef enum logic [3:0] {
		KIND_ABORT = 4'd0,
		KIND_FOLD  = 4'd1,
		KIND_RESET = 4'd2,
		KIND_LSSOF = 4'd3,
		KIND_ERROR = 4'd4,
		KIND_SOF   = 4'd5,
		KIND_TOKEN = 4'd6,
		KIND_HSHK  = 4'd7,
		KIND_DATA  = 4'd8,
		KIND_SIMPLE = 4'd9,
		KIND_SPLIT = 4'd10
	} kind_t;

	// Packet identifiers
	localparam logic [3:0] PID_OUT       = 4'h1;
	localparam logic [3:0] PID_ACK       = 4'h2;
	localparam logic [3:0] PID_DAT0      = 4'h3;
	localparam logic [3:0] PID_SOF       = 4'h5;
	localparam logic [3:0] PID_NOTYET    = 4'h6;
	localparam logic [3:0] PID_DAT2      = 4'h7;
	localparam logic [3:0] PID_SPLT      = 4'h8;
	localparam logic [3:0] PID_IN        = 4'h9;
	localparam logic [3:0] PID_NAK       = 4'hA;
	localparam logic [3:0] PID_DAT1      = 4'hB;
	localparam logic [3:0] PID_CTL_SETUP = 4'hD;
	localparam logic [3:0] PID_STL       = 4'hE;
	localparam logic [3:0] PID_MDAT      = 4'hF;

	// Register indexes
	localparam logic [1:0] CFG_TIME_REF  = 2'd0;
	localparam logic [1:0] CFG_FOLD_EN   = 2'd1;
	localparam logic [1:0] CFG_DATA_LIM  = 2'd2;
	localparam logic [1:0] CFG_MAX_GAP   = 2'd3;
	localparam int CFG_DATA_W = 31;

	// Time reference modes
	localparam logic [1:0] TREF_FIRST = 2'd0;
	localparam logic [1:0] TREF_PREV  = 2'd1;
	localparam logic [1:0] TREF_SOF   = 2'd2;
	localparam logic [1:0] TREF_RESET = 2'd3;

	// Data display limit modes
	localparam logic [1:0] DLIM_NONE = 2'd0;
	localparam logic [1:0] DLIM_16   = 2'd1;
	localparam logic [1:0] DLIM_64   = 2'd2;
	localparam logic [1:0] DLIM_ALL  = 2'd3;
	localparam logic [10:0] DLIM_16_BYTES = 11'd16;
	localparam logic [10:0] DLIM_64_BYTES = 11'd64;

	// Error records show at most this many captured bytes, minus two for sync and pid
	localparam int ERROR_SHOW_LIMIT = 16;

	localparam logic [15:0] FOLD_MAX = 16'hffff;
	localparam logic [30:0] MAX_GAP_RESET = 31'd10000;

	// Result queue geometry
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	typedef struct packed {
		logic [1:0]  time_ref_mode;
		logic        fold_enable;
		logic [1:0]  data_limit_mode;
		logic [30:0] max_gap;
	} cfg_t;

	typedef struct packed {
		logic        func;
		logic        first_record;
		logic [31:0] timestamp;
		logic        flag_reset;
		logic        flag_ls_sof;
		logic        flag_may_fold;
		logic [5:0]  error_bits;
		logic [10:0] byte_count;
		logic [7:0]  pid_byte;
		logic [7:0]  payload_b2;
		logic [7:0]  payload_b3;
		logic [7:0]  payload_b4;
	} item_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] rel_time;
		logic [3:0]  pid_code;
		logic [10:0] field_a;
		logic [6:0]  field_b;
		logic [4:0]  split_bits;
		logic [15:0] count;
		logic [10:0] shown_bytes;
		logic        truncated;
		logic [5:0]  errors_out;
		logic        last;
	} result_t;

endpackage

`default_nettype wire

>>> hdl/usb_capture_record_classifier.sv
`timescale 1ns / 1ps
`default_nettype none

// Classifies captured USB packet records, one word per cycle on the record
// channel while rec_stall is low. A record is registered, classified
// combinationally against the fold, abort and time reference state, and its
// results (none, one, or a fold summary followed by the packet) go into a
// four-word result queue that drives the result port. Records enter every
// cycle while the queue has room for two words; the result port drains one
// word per cycle while res_stall is low, so a record that yields two results
// costs two words of output bandwidth. Registers are written through
// cfg_we/cfg_index/cfg_data and should change only while no record is in flight.

module usb_capture_record_classifier (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [ucrc_pkg::CFG_DATA_W-1:0] cfg_data,
	// record channel
	input  logic        rec_valid,
	output logic        rec_stall,
	input  logic        func,
	input  logic        first_record,
	input  logic [31:0] timestamp,
	input  logic        flag_reset,
	input  logic        flag_ls_sof,
	input  logic        flag_may_fold,
	input  logic [5:0]  error_bits,
	input  logic [10:0] byte_count,
	input  logic [7:0]  pid_byte,
	input  logic [7:0]  payload_b2,
	input  logic [7:0]  payload_b3,
	input  logic [7:0]  payload_b4,
	// result channel
	output logic        res_valid,
	input  logic        res_stall,
	output logic [3:0]  kind,
	output logic [31:0] rel_time,
	output logic [3:0]  pid_code,
	output logic [10:0] field_a,
	output logic [6:0]  field_b,
	output logic [4:0]  split_bits,
	output logic [15:0] count,
	output logic [10:0] shown_bytes,
	output logic        truncated,
	output logic [5:0]  errors_out,
	output logic        last
);
	import ucrc_pkg::*;

	cfg_t     cfg_q;
	item_t    item_s1;
	logic     vld_s1;
	logic     accept, fire, room, not_empty;
	result_t  res0, res1, head;
	logic [1:0] push_n;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.time_ref_mode <= TREF_FIRST;
			cfg_q.fold_enable <= 1'b1;
			cfg_q.data_limit_mode <= DLIM_64;
			cfg_q.max_gap <= MAX_GAP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TIME_REF: cfg_q.time_ref_mode <= cfg_data[1:0];
				CFG_FOLD_EN:  cfg_q.fold_enable <= cfg_data[0];
				CFG_DATA_LIM: cfg_q.data_limit_mode <= cfg_data[1:0];
				CFG_MAX_GAP:  cfg_q.max_gap <= cfg_data[CFG_DATA_W-1:0];
				default:      cfg_q <= cfg_q;
			endcase
		end
	end

	// Input register: take a word when it is empty or the held one moves on
	assign fire      = vld_s1 && room;
	assign rec_stall = vld_s1 && !room;
	assign accept    = rec_valid && !rec_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept || (vld_s1 && !fire);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= '{func: func, first_record: first_record,
				timestamp: timestamp, flag_reset: flag_reset,
				flag_ls_sof: flag_ls_sof, flag_may_fold: flag_may_fold,
				error_bits: error_bits, byte_count: byte_count,
				pid_byte: pid_byte, payload_b2: payload_b2,
				payload_b3: payload_b3, payload_b4: payload_b4};
		end
	end

	ucrc_classify u_classify (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.item   (item_s1),
		.fire   (fire),
		.res0   (res0),
		.res1   (res1),
		.push_n (push_n)
	);

	ucrc_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr0       (res0),
		.wr1       (res1),
		.push_n    (push_n),
		.pop       (res_valid && !res_stall),
		.head      (head),
		.not_empty (not_empty),
		.room      (room)
	);

	// Drive result ports from the queue head
	assign res_valid   = not_empty;
	assign kind        = head.kind;
	assign rel_time    = head.rel_time;
	assign pid_code    = head.pid_code;
	assign field_a     = head.field_a;
	assign field_b     = head.field_b;
	assign split_bits  = head.split_bits;
	assign count       = head.count;
	assign shown_bytes = head.shown_bytes;
	assign truncated   = head.truncated;
	assign errors_out  = head.errors_out;
	assign last        = head.last;

endmodule

`default_nettype wire

>>> hdl/ucrc_classify.sv
`timescale 1ns / 1ps
`default_nettype none

`include "usb_capture_record_classifier_assert.svh"

module ucrc_classify (
	input  logic             clk,
	input  logic             arst_n,
	input  ucrc_pkg::cfg_t   cfg,
	input  ucrc_pkg::item_t  item,
	input  logic             fire,
	output ucrc_pkg::result_t res0,
	output ucrc_pkg::result_t res1,
	output logic [1:0]       push_n
);
	import ucrc_pkg::*;

	logic [31:0] ref_q, prev_q;
	logic        gap_q, folding_q, aborted_q;
	logic [15:0] cnt_q;

	logic [31:0] ref_d, prev_d;
	logic        gap_d, folding_d, aborted_d;
	logic [15:0] cnt_d;

	logic [31:0] ts, ref_e, prev_e, delta, ftime;
	logic        gap_e, gap_fail, ref_take, pid_sof, emit;
	logic [3:0]  pid;
	logic [15:0] v;
	logic [10:0] size, len, dshown, elim;
	result_t     pkt, r0, r1;
	logic [1:0]  n;
	logic        pair_push, pair_ok, abort_push;

	// Apply first-record initialization before the record is looked at
	assign ts     = item.timestamp;
	assign ref_e  = item.first_record ? ts : ref_q;
	assign prev_e = item.first_record ? ts : prev_q;
	assign gap_e  = item.first_record | gap_q;

	// Gap test: backward steps never abort
	assign delta    = ts - prev_e;
	assign gap_fail = gap_e && !delta[31] && (delta > {1'b0, cfg.max_gap});
	assign ftime    = ts - ref_e;

	assign pid      = item.flag_ls_sof ? PID_SOF : item.pid_byte[3:0];
	assign pid_sof  = (pid == PID_SOF);
	assign ref_take = (cfg.time_ref_mode == TREF_PREV)
		|| ((cfg.time_ref_mode == TREF_SOF) && pid_sof);

	assign v    = {item.payload_b3, item.payload_b2};
	assign size = item.byte_count;
	assign len  = (size < 11'd4) ? '0 : size - 11'd4;
	assign elim = (size > 11'(ERROR_SHOW_LIMIT)) ? 11'(ERROR_SHOW_LIMIT) : size;

	// Clamp shown data bytes
	always_comb begin
		case (cfg.data_limit_mode)
			DLIM_NONE: dshown = '0;
			DLIM_16:   dshown = (len < DLIM_16_BYTES) ? len : DLIM_16_BYTES;
			DLIM_64:   dshown = (len < DLIM_64_BYTES) ? len : DLIM_64_BYTES;
			default:   dshown = len;
		endcase
	end

	// Build the packet result
	always_comb begin
		pkt = '0;
		pkt.rel_time = ftime;
		pkt.pid_code = pid;
		if (item.flag_reset) begin
			pkt.kind = KIND_RESET;
		end else if (item.flag_ls_sof) begin
			pkt.kind = KIND_LSSOF;
		end else if (item.error_bits != '0) begin
			pkt.kind = KIND_ERROR;
			pkt.count = {5'd0, size};
			pkt.errors_out = item.error_bits;
			if (size > 11'd2) begin
				pkt.shown_bytes = elim - 11'd2;
				pkt.truncated = (size > 11'(ERROR_SHOW_LIMIT));
			end
		end else begin
			case (pid) inside
				PID_SOF: begin
					pkt.kind = KIND_SOF;
					pkt.field_a = v[10:0];
				end
				PID_OUT, PID_IN, PID_CTL_SETUP: begin
					pkt.kind = KIND_TOKEN;
					pkt.field_a = {4'd0, v[6:0]};
					pkt.field_b = {3'd0, v[10:7]};
				end
				PID_ACK, PID_NAK, PID_STL, PID_NOTYET: begin
					pkt.kind = KIND_HSHK;
				end
				PID_DAT0, PID_DAT1, PID_DAT2, PID_MDAT: begin
					pkt.kind = KIND_DATA;
					pkt.count = {5'd0, len};
					pkt.shown_bytes = dshown;
					pkt.truncated = (dshown < len);
				end
				PID_SPLT: begin
					pkt.kind = KIND_SPLIT;
					pkt.field_a = {4'd0, item.payload_b2[6:0]};
					pkt.field_b = item.payload_b3[6:0];
					pkt.split_bits = {item.payload_b4[2:1], item.payload_b4[0],
						item.payload_b3[7], item.payload_b2[7]};
				end
				default: begin
					pkt.kind = KIND_SIMPLE;
				end
			endcase
		end
	end

	// Sequence the record against the fold and abort state
	always_comb begin
		ref_d = ref_q;
		prev_d = prev_q;
		gap_d = gap_q;
		folding_d = folding_q;
		cnt_d = cnt_q;
		aborted_d = aborted_q;
		r0 = '0;
		r1 = '0;
		n = 2'd0;
		emit = 1'b0;
		if (item.func) begin
			// End of capture: flush a pending fold
			if (folding_q && (cnt_q != '0)) begin
				r0.kind = KIND_FOLD;
				r0.count = cnt_q;
				n = 2'd1;
			end
			folding_d = 1'b0;
			cnt_d = '0;
		end else begin
			if (item.first_record) begin
				ref_d = ts;
				prev_d = ts;
				folding_d = 1'b0;
				cnt_d = '0;
				gap_d = 1'b1;
				aborted_d = 1'b0;
			end
			if (!aborted_d) begin
				if (gap_fail) begin
					aborted_d = 1'b1;
					r0.kind = KIND_ABORT;
					n = 2'd1;
				end else begin
					prev_d = ts;
					gap_d = 1'b1;
					if (ref_take) begin
						ref_d = ts;
					end
					emit = 1'b1;
					if (folding_d) begin
						if (!pid_sof) begin
							emit = 1'b0;
						end else if (item.flag_may_fold) begin
							emit = 1'b0;
							if (cnt_d != FOLD_MAX) begin
								cnt_d = cnt_d + 16'd1;
							end
						end else begin
							r0.kind = KIND_FOLD;
							r0.count = cnt_d;
							n = 2'd1;
							folding_d = 1'b0;
						end
					end
					if (emit) begin
						if (item.flag_may_fold && cfg.fold_enable) begin
							folding_d = 1'b1;
							cnt_d = 16'd1;
						end else begin
							if (n == 2'd0) begin
								r0 = pkt;
							end else begin
								r1 = pkt;
							end
							n = n + 2'd1;
							if (item.flag_reset) begin
								gap_d = 1'b0;
								if (cfg.time_ref_mode == TREF_RESET) begin
									ref_d = ts;
								end
							end
						end
					end
				end
			end
		end
		// Mark the final result of the record
		if (n == 2'd1) begin
			r0.last = 1'b1;
		end
		if (n == 2'd2) begin
			r1.last = 1'b1;
		end
	end

	assign res0   = r0;
	assign res1   = r1;
	assign push_n = fire ? n : 2'd0;

	// Hold state, advance on each processed record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q <= '0;
			prev_q <= '0;
			gap_q <= 1'b1;
			folding_q <= 1'b0;
			cnt_q <= '0;
			aborted_q <= 1'b0;
		end else if (fire) begin
			ref_q <= ref_d;
			prev_q <= prev_d;
			gap_q <= gap_d;
			folding_q <= folding_d;
			cnt_q <= cnt_d;
			aborted_q <= aborted_d;
		end
	end

	assign pair_push  = fire && (push_n == 2'd2);
	assign pair_ok    = (res0.kind == KIND_FOLD) && !res0.last && res1.last;
	assign abort_push = fire && (push_n != 2'd0) && (res0.kind == KIND_ABORT);

	`UCRC_ASSERT_NOW(a_pair_leads_fold, pair_push, pair_ok, "bad result pair")
	`UCRC_ASSERT_NEXT(a_abort_sticks, abort_push, aborted_q, "abort did not stick")
	`UCRC_ASSERT_NOW(a_single_last, fire && (push_n == 2'd1), res0.last, "single word not last")

endmodule

`default_nettype wire

>>> hdl/ucrc_outq.sv
`timescale 1ns / 1ps
`default_nettype none

`include "usb_capture_record_classifier_assert.svh"

module ucrc_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  ucrc_pkg::result_t wr0,
	input  ucrc_pkg::result_t wr1,
	input  logic [1:0]        push_n,
	input  logic              pop,
	output ucrc_pkg::result_t head,
	output logic              not_empty,
	output logic              room
);
	import ucrc_pkg::*;

	result_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_q, rd_q;
	logic [QCNT_W-1:0]   cnt_q;

	assign head      = mem_q[rd_q];
	assign not_empty = (cnt_q != '0);
	assign room      = (cnt_q <= QCNT_W'(QDEPTH - 2));

	// Store up to two words per cycle
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_q] <= wr0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_q + QPTR_W'(1)] <= wr1;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + QPTR_W'(push_n);
			rd_q <= rd_q + QPTR_W'(pop);
			cnt_q <= cnt_q + QCNT_W'(push_n) - QCNT_W'(pop);
		end
	end

	`UCRC_ASSERT_NOW(a_pop_nonempty, pop, cnt_q != '0, "pop from empty queue")
	`UCRC_ASSERT_NOW(a_push_room, push_n != 2'd0, room, "push without room")
	`UCRC_ASSERT_NOW(a_count_bound, 1'b1, cnt_q <= QCNT_W'(QDEPTH), "queue count beyond depth")

endmodule

`default_nettype wire

>>> sim/record_result_monitor.sv
`timescale 1ns / 1ps

module record_result_monitor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [30:0] cfg_data,
	input  logic        rec_valid,
	input  logic        rec_stall,
	input  logic        func,
	input  logic        first_record,
	input  logic [31:0] timestamp,
	input  logic        flag_reset,
	input  logic        flag_ls_sof,
	input  logic        flag_may_fold,
	input  logic [5:0]  error_bits,
	input  logic [10:0] byte_count,
	input  logic [7:0]  pid_byte,
	input  logic [7:0]  payload_b2,
	input  logic [7:0]  payload_b3,
	input  logic [7:0]  payload_b4,
	input  logic        res_valid,
	input  logic        res_stall,
	input  logic [3:0]  kind,
	input  logic [31:0] rel_time,
	input  logic [3:0]  pid_code,
	input  logic [10:0] field_a,
	input  logic [6:0]  field_b,
	input  logic [4:0]  split_bits,
	input  logic [15:0] count,
	input  logic [10:0] shown_bytes,
	input  logic        truncated,
	input  logic [5:0]  errors_out,
	input  logic        last,
	output int          mismatch_count,
	output int          outstanding
);
	import ucrc_pkg::*;

	// Register copies
	logic [1:0]  time_ref_mode;
	logic        fold_enable;
	logic [1:0]  data_limit_mode;
	logic [30:0] max_gap;

	// Capture state
	logic [31:0] ref_time;
	logic [31:0] prev_time;
	logic        gap_check_on;
	logic        folding;
	logic [15:0] fold_count;
	logic        aborted;

	result_t expected_results[$];
	result_t want;

	function automatic result_t blank_result(input kind_t k);
		result_t res;
		res = '0;
		res.kind = k;
		return res;
	endfunction

	// Build the word for a record that reaches the packet decoder
	function automatic result_t packet_result(input item_t r, input logic [3:0] pid,
			input logic [31:0] ftime);
		result_t res;
		logic [15:0] v;
		logic [10:0] len;
		logic [10:0] shown;
		res = blank_result(KIND_SIMPLE);
		res.rel_time = ftime;
		res.pid_code = pid;
		v = {r.payload_b3, r.payload_b2};
		if (r.flag_reset) begin
			res.kind = KIND_RESET;
		end else if (r.flag_ls_sof) begin
			res.kind = KIND_LSSOF;
		end else if (r.error_bits != 6'd0) begin
			res.kind = KIND_ERROR;
			res.count = {5'd0, r.byte_count};
			res.errors_out = r.error_bits;
			// keep at most the show limit, minus sync and pid
			if (r.byte_count > 11'd2) begin
				len = (r.byte_count > ERROR_SHOW_LIMIT) ? 11'(ERROR_SHOW_LIMIT) : r.byte_count;
				res.shown_bytes = len - 11'd2;
				res.truncated = (r.byte_count > ERROR_SHOW_LIMIT);
			end
		end else begin
			case (pid)
				PID_SOF: begin
					res.kind = KIND_SOF;
					res.field_a = v[10:0];
				end
				PID_OUT, PID_IN, PID_CTL_SETUP: begin
					res.kind = KIND_TOKEN;
					res.field_a = {4'd0, v[6:0]};
					res.field_b = {3'd0, v[10:7]};
				end
				PID_ACK, PID_NAK, PID_STL, PID_NOTYET: begin
					res.kind = KIND_HSHK;
				end
				PID_DAT0, PID_DAT1, PID_DAT2, PID_MDAT: begin
					res.kind = KIND_DATA;
					len = (r.byte_count < 11'd4) ? 11'd0 : r.byte_count - 11'd4;
					case (data_limit_mode)
						DLIM_NONE: shown = 11'd0;
						DLIM_16:   shown = (len < DLIM_16_BYTES) ? len : DLIM_16_BYTES;
						DLIM_64:   shown = (len < DLIM_64_BYTES) ? len : DLIM_64_BYTES;
						default:   shown = len;
					endcase
					res.count = {5'd0, len};
					res.shown_bytes = shown;
					res.truncated = (shown < len);
				end
				PID_SPLT: begin
					res.kind = KIND_SPLIT;
					res.field_a = {4'd0, r.payload_b2[6:0]};
					res.field_b = r.payload_b3[6:0];
					res.split_bits = {r.payload_b4[2:1], r.payload_b4[0],
						r.payload_b3[7], r.payload_b2[7]};
				end
				default: res.kind = KIND_SIMPLE;
			endcase
		end
		return res;
	endfunction

	// Advance the capture state by one record and queue the words it yields
	task automatic classify_record(input item_t r);
		result_t words[2];
		result_t tmp;
		int n;
		int i;
		logic [31:0] delta;
		logic [31:0] ftime;
		logic [3:0] pid;
		logic swallowed;
		n = 0;
		if (r.func) begin
			// end of capture: flush a pending fold
			if (folding && fold_count != 16'd0) begin
				words[n] = blank_result(KIND_FOLD);
				words[n].count = fold_count;
				n++;
			end
			folding = 1'b0;
			fold_count = 16'd0;
		end else begin
			if (r.first_record) begin
				ref_time = r.timestamp;
				prev_time = r.timestamp;
				folding = 1'b0;
				fold_count = 16'd0;
				gap_check_on = 1'b1;
				aborted = 1'b0;
			end
			if (!aborted) begin
				delta = r.timestamp - prev_time;
				// a backward step reads as negative and never aborts
				if (gap_check_on && !delta[31] && delta > {1'b0, max_gap}) begin
					aborted = 1'b1;
					words[n] = blank_result(KIND_ABORT);
					n++;
				end else begin
					ftime = r.timestamp - ref_time;
					prev_time = r.timestamp;
					gap_check_on = 1'b1;
					pid = r.flag_ls_sof ? PID_SOF : r.pid_byte[3:0];
					if ((time_ref_mode == TREF_SOF && pid == PID_SOF) ||
							time_ref_mode == TREF_PREV)
						ref_time = r.timestamp;
					swallowed = 1'b0;
					if (folding) begin
						if (pid != PID_SOF) begin
							swallowed = 1'b1;
						end else if (r.flag_may_fold) begin
							if (fold_count != FOLD_MAX)
								fold_count = fold_count + 16'd1;
							swallowed = 1'b1;
						end else begin
							words[n] = blank_result(KIND_FOLD);
							words[n].count = fold_count;
							n++;
							folding = 1'b0;
						end
					end
					if (!swallowed) begin
						if (r.flag_may_fold && fold_enable) begin
							folding = 1'b1;
							fold_count = 16'd1;
						end else begin
							words[n] = packet_result(r, pid, ftime);
							n++;
							if (r.flag_reset) begin
								if (time_ref_mode == TREF_RESET)
									ref_time = r.timestamp;
								gap_check_on = 1'b0;
							end
						end
					end
				end
			end
		end
		for (i = 0; i < n; i++) begin
			tmp = words[i];
			tmp.last = (i == n - 1);
			expected_results.push_back(tmp);
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (exp_val !== act_val) begin
			$error("%s: expected %0h, got %0h", name, exp_val, act_val);
			mismatch_count++;
		end
	endtask

	// Watch both channels and the register port
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_ref_mode = TREF_FIRST;
			fold_enable = 1'b1;
			data_limit_mode = DLIM_64;
			max_gap = MAX_GAP_RESET;
			ref_time = 32'd0;
			prev_time = 32'd0;
			gap_check_on = 1'b1;
			folding = 1'b0;
			fold_count = 16'd0;
			aborted = 1'b0;
			expected_results.delete();
			mismatch_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_TIME_REF: time_ref_mode = cfg_data[1:0];
					CFG_FOLD_EN:  fold_enable = cfg_data[0];
					CFG_DATA_LIM: data_limit_mode = cfg_data[1:0];
					default:      max_gap = cfg_data;
				endcase
			end
			// compare a result word with the oldest expectation
			if (res_valid && !res_stall) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result word: kind %0d", kind);
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("kind", want.kind, kind);
					check_field("rel_time", want.rel_time, rel_time);
					check_field("pid_code", want.pid_code, pid_code);
					check_field("field_a", want.field_a, field_a);
					check_field("field_b", want.field_b, field_b);
					check_field("split_bits", want.split_bits, split_bits);
					check_field("count", want.count, count);
					check_field("shown_bytes", want.shown_bytes, shown_bytes);
					check_field("truncated", want.truncated, truncated);
					check_field("errors_out", want.errors_out, errors_out);
					check_field("last", want.last, last);
				end
			end
			if (rec_valid && !rec_stall)
				classify_record({func, first_record, timestamp, flag_reset, flag_ls_sof,
					flag_may_fold, error_bits, byte_count, pid_byte, payload_b2,
					payload_b3, payload_b4});
		end
		outstanding = expected_results.size();
	end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import ucrc_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 107;
	localparam int PRESSURE_PHASE = 4;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES = 20;
	localparam int FOLD_FRAMES = 20;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [30:0] cfg_data;
	logic        rec_valid;
	logic        rec_stall;
	logic        func;
	logic        first_record;
	logic [31:0] timestamp;
	logic        flag_reset;
	logic        flag_ls_sof;
	logic        flag_may_fold;
	logic [5:0]  error_bits;
	logic [10:0] byte_count;
	logic [7:0]  pid_byte;
	logic [7:0]  payload_b2;
	logic [7:0]  payload_b3;
	logic [7:0]  payload_b4;
	logic        res_valid;
	logic        res_stall;
	logic [3:0]  kind;
	logic [31:0] rel_time;
	logic [3:0]  pid_code;
	logic [10:0] field_a;
	logic [6:0]  field_b;
	logic [4:0]  split_bits;
	logic [15:0] count;
	logic [10:0] shown_bytes;
	logic        truncated;
	logic [5:0]  errors_out;
	logic        last;
	int          mismatch_count;
	int          outstanding;

	bit          idling = 1'b1;
	bit          long_hold = 1'b0;
	logic [31:0] stamp;
	int unsigned cycle_count = 0;

	usb_capture_record_classifier DUT (.*);

	record_result_monitor monitor (.*);

	always #5 clk = ~clk;

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	// Receiver: random stall bursts, and one long hold-off on request
	initial begin
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				res_stall = 1'b1;
				repeat (LONG_HOLD_CYCLES) @(negedge clk);
				res_stall = 1'b0;
				long_hold = 1'b0;
			end else if (idling && $urandom_range(0, 5) == 0) begin
				res_stall = 1'b1;
				repeat ($urandom_range(1, 15)) @(negedge clk);
				res_stall = 1'b0;
			end
		end
	end

	task automatic drive_record(input item_t r);
		func = r.func;
		first_record = r.first_record;
		timestamp = r.timestamp;
		flag_reset = r.flag_reset;
		flag_ls_sof = r.flag_ls_sof;
		flag_may_fold = r.flag_may_fold;
		error_bits = r.error_bits;
		byte_count = r.byte_count;
		pid_byte = r.pid_byte;
		payload_b2 = r.payload_b2;
		payload_b3 = r.payload_b3;
		payload_b4 = r.payload_b4;
	endtask

	// Offer one record word and hold it until the block takes it
	task automatic offer_record(input item_t r);
		if (idling && $urandom_range(0, 4) == 0) begin
			rec_valid = 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		drive_record(r);
		rec_valid = 1'b1;
		do @(posedge clk); while (rec_stall);
		@(negedge clk);
	endtask

	// Write a register once the block has gone quiet
	task automatic write_reg(input logic [1:0] index, input logic [30:0] data);
		rec_valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = index;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Directed packet record seven timestamp units after the previous one
	function automatic item_t rec(input logic [3:0] pid, input logic [10:0] size,
			input logic [7:0] b2, input logic [7:0] b3, input logic [7:0] b4);
		item_t r;
		r = '0;
		stamp = stamp + 32'd7;
		r.timestamp = stamp;
		r.pid_byte = {~pid, pid};
		r.byte_count = size;
		r.payload_b2 = b2;
		r.payload_b3 = b3;
		r.payload_b4 = b4;
		return r;
	endfunction

	// Random record: mostly a plausible capture stream, with some noise
	task automatic next_record(output item_t r);
		int pick;
		logic [3:0] pid;
		r = '0;
		r.pid_byte = 8'($urandom);
		r.payload_b2 = 8'($urandom);
		r.payload_b3 = 8'($urandom);
		r.payload_b4 = 8'($urandom);
		r.byte_count = ($urandom_range(0, 7) == 0) ? 11'($urandom) : 11'($urandom_range(0, 80));
		// advance time: repeat, small step, or jump anywhere
		pick = $urandom_range(0, 99);
		if (pick >= 97)
			stamp = $urandom;
		else if (pick >= 8)
			stamp = stamp + 32'($urandom_range(1, 1200));
		r.timestamp = stamp;
		pick = $urandom_range(0, 99);
		if (pick < 3) begin
			r.func = 1'b1;
			r.first_record = 1'($urandom);
			r.flag_may_fold = 1'($urandom);
		end else begin
			r.first_record = (pick < 7);
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				pid = PID_SOF;
				r.flag_may_fold = 1'($urandom);
			end else if (pick < 48) begin
				case ($urandom_range(0, 2))
					0: pid = PID_OUT;
					1: pid = PID_IN;
					default: pid = PID_CTL_SETUP;
				endcase
			end else if (pick < 66) begin
				case ($urandom_range(0, 3))
					0: pid = PID_DAT0;
					1: pid = PID_DAT1;
					2: pid = PID_DAT2;
					default: pid = PID_MDAT;
				endcase
			end else if (pick < 78) begin
				case ($urandom_range(0, 3))
					0: pid = PID_ACK;
					1: pid = PID_NAK;
					2: pid = PID_STL;
					default: pid = PID_NOTYET;
				endcase
			end else if (pick < 84) begin
				pid = PID_SPLT;
			end else begin
				pid = 4'($urandom);
			end
			r.pid_byte[3:0] = pid;
			r.error_bits = ($urandom_range(0, 19) == 0) ? 6'($urandom_range(1, 63)) : 6'd0;
			r.flag_reset = ($urandom_range(0, 29) == 0);
			r.flag_ls_sof = ($urandom_range(0, 29) == 0);
			if ($urandom_range(0, 24) == 0)
				r.flag_may_fold = 1'b1;
		end
	endtask

	initial begin
		item_t r;
		int phase;
		int i;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_TIME_REF;
		cfg_data = '0;
		rec_valid = 1'b0;
		drive_record('0);
		stamp = 32'hffff_fff0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: every packet class and field extreme, reset register values
		r = rec(PID_SOF, 11'd5, 8'hff, 8'hff, 8'h00);
		r.first_record = 1'b1;
		offer_record(r);
		offer_record(rec(PID_OUT, 11'd5, 8'hff, 8'hff, 8'h00));
		offer_record(rec(PID_IN, 11'd5, 8'h00, 8'h00, 8'h00));
		offer_record(rec(PID_CTL_SETUP, 11'd5, 8'h85, 8'h02, 8'h00));
		offer_record(rec(PID_ACK, 11'd2, 8'h00, 8'h00, 8'h00));
		offer_record(rec(PID_NOTYET, 11'd2, 8'h00, 8'h00, 8'h00));
		offer_record(rec(PID_DAT0, 11'd0, 8'h00, 8'h00, 8'h00));
		offer_record(rec(PID_DAT1, 11'd3, 8'h00, 8'h00, 8'h00));
		offer_record(rec(PID_MDAT, 11'd2047, 8'hff, 8'hff, 8'hff));
		offer_record(rec(PID_SPLT, 11'd6, 8'hff, 8'hff, 8'hff));
		offer_record(rec(PID_SPLT, 11'd6, 8'h00, 8'h00, 8'h00));
		offer_record(rec(4'h0, 11'd2, 8'h00, 8'h00, 8'h00));
		// error records: short, just long enough, truncated
		r = rec(PID_DAT2, 11'd2, 8'h00, 8'h00, 8'h00);
		r.error_bits = 6'h3f;
		offer_record(r);
		r = rec(PID_OUT, 11'd3, 8'h00, 8'h00, 8'h00);
		r.error_bits = 6'h01;
		offer_record(r);
		r = rec(PID_DAT0, 11'd17, 8'h00, 8'h00, 8'h00);
		r.error_bits = 6'h20;
		offer_record(r);
		r = rec(PID_ACK, 11'd3, 8'h00, 8'h00, 8'h00);
		r.flag_ls_sof = 1'b1;
		offer_record(r);
		r = rec(PID_DAT1, 11'd0, 8'h00, 8'h00, 8'h00);
		r.flag_reset = 1'b1;
		offer_record(r);
		// fold run: a non-SOF inside is dropped, a plain SOF closes it
		r = rec(PID_SOF, 11'd5, 8'h01, 8'h00, 8'h00);
		r.flag_may_fold = 1'b1;
		offer_record(r);
		offer_record(r);
		offer_record(rec(PID_DAT0, 11'd8, 8'h00, 8'h00, 8'h00));
		offer_record(rec(PID_SOF, 11'd5, 8'h04, 8'h00, 8'h00));
		// run a longer fold back to back, then flush it with an end word
		idling = 1'b0;
		r = rec(PID_SOF, 11'd5, 8'h05, 8'h00, 8'h00);
		r.flag_may_fold = 1'b1;
		for (i = 0; i < FOLD_FRAMES; i++) begin
			r.timestamp = r.timestamp + 32'd1;
			offer_record(r);
		end
		stamp = r.timestamp;
		idling = 1'b1;
		r = rec(PID_SOF, 11'd5, 8'h00, 8'h00, 8'h00);
		r.func = 1'b1;
		offer_record(r);
		offer_record(r);
		// backward step, then a gap that aborts, an ignored record and a restart
		r = rec(PID_IN, 11'd5, 8'h12, 8'h34, 8'h00);
		r.timestamp = stamp - 32'd1000;
		stamp = r.timestamp;
		offer_record(r);
		r = rec(PID_OUT, 11'd5, 8'h00, 8'h00, 8'h00);
		r.timestamp = stamp + 32'd20000;
		stamp = r.timestamp;
		offer_record(r);
		offer_record(rec(PID_IN, 11'd5, 8'h00, 8'h00, 8'h00));
		r = rec(PID_SOF, 11'd5, 8'h10, 8'h00, 8'h00);
		r.first_record = 1'b1;
		offer_record(r);

		// Random phases across register settings
		for (phase = 0; phase < PHASES; phase++) begin
			idling = (phase != PHASES - 1) && (phase != PRESSURE_PHASE);
			write_reg(CFG_TIME_REF, 31'(phase % 4));
			write_reg(CFG_FOLD_EN, 31'(phase % 3 != 1));
			write_reg(CFG_DATA_LIM, 31'((phase * 3) % 4));
			case (phase)
				1: write_reg(CFG_MAX_GAP, 31'd0);
				2: write_reg(CFG_MAX_GAP, 31'h7fff_ffff);
				3: write_reg(CFG_MAX_GAP, 31'($urandom_range(200, 3000)));
				5: write_reg(CFG_MAX_GAP, 31'($urandom));
				default: write_reg(CFG_MAX_GAP, MAX_GAP_RESET);
			endcase
			if (phase == PRESSURE_PHASE)
				long_hold = 1'b1;
			for (i = 0; i < PHASE_ITEMS; i++) begin
				next_record(r);
				offer_record(r);
			end
		end

		// Drain and decide
		rec_valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
